// ===== design/kgsr_pkg.sv =====
// Shared constants, types and helpers for the k-group stream reverser.
// Used by kgsr_group_mem, kgsr_seq and k_group_stream_reverser_core.
package kgsr_pkg;

   localparam int MAX_GROUP  = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(MAX_GROUP);
   localparam int CNT_W      = $clog2(MAX_GROUP + 1);
   localparam int CFG_W      = 7;

   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

   // Memory access request from the sequencer
   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } mem_req_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] fill;
   } seq_status_type;

   // Map the raw register onto 1..MAX_GROUP
   function automatic logic [CNT_W-1:0] effective_group(input logic [CFG_W-1:0] gs);
      logic [CNT_W-1:0] k;
      if (gs == '0) begin
         k = CNT_W'(1);
      end else if (CNT_W'(gs) > CNT_W'(MAX_GROUP)) begin
         k = CNT_W'(MAX_GROUP);
      end else begin
         k = CNT_W'(gs);
      end
      return k;
   endfunction

endpackage

// ===== design/kgsr_group_mem.sv =====
// Group buffer: one write port, one read port, registered read data.
// Depends on kgsr_pkg for depth, widths and the request struct.
module kgsr_group_mem
   import kgsr_pkg::*;
(
   input  logic                  clock,
   input  mem_req_type           mem_req,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_array [MAX_GROUP];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write an item and read one entry per cycle
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_array[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kgsr_seq.sv =====
// Sequencer: stores items, decides when a group flushes, reads it back
// through the group buffer and drives the result register. Uses kgsr_pkg.
module kgsr_seq
   import kgsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      group_k,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_item_value,
   input  logic                  req_end_of_list,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_out_value,
   output logic                  rsp_last_of_run,
   output logic                  rsp_list_done,
   output mem_req_type           mem_req,
   input  logic [DATA_WIDTH-1:0] rd_data,
   output seq_status_type        status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_LOAD
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic                  rev_ff, rev_in;
   logic                  eol_ff, eol_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic                  rsp_last_ff, rsp_done_ff;

   logic             req_take;
   logic             out_free;
   logic             load;
   logic [CNT_W-1:0] n_items;
   logic             last_one;

   assign req_take = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == S_LOAD) && out_free;
   assign n_items  = fill_ff + CNT_W'(1);
   assign last_one = (remain_ff == CNT_W'(1));

   // Next-state logic
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      remain_in = remain_ff;
      idx_in    = idx_ff;
      rev_in    = rev_ff;
      eol_in    = eol_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               eol_in = req_end_of_list;
               if (n_items >= group_k) begin
                  // full group: read back newest first
                  fill_in   = '0;
                  remain_in = n_items;
                  idx_in    = fill_ff[ADDR_W-1:0];
                  rev_in    = 1'b1;
                  state_in  = S_FETCH;
               end else if (req_end_of_list) begin
                  // partial group at end: read back oldest first
                  fill_in   = '0;
                  remain_in = n_items;
                  idx_in    = '0;
                  rev_in    = 1'b0;
                  state_in  = S_FETCH;
               end else begin
                  fill_in = n_items;
               end
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load) begin
               remain_in = remain_ff - CNT_W'(1);
               idx_in    = rev_ff ? idx_ff - ADDR_W'(1) : idx_ff + ADDR_W'(1);
               state_in  = last_one ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold a result until taken, load the next one when free
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      rev_ff <= rev_in;
      eol_ff <= eol_in;
      if (load) begin
         rsp_value_ff <= rd_data;
         rsp_last_ff  <= last_one;
         rsp_done_ff  <= last_one && eol_ff;
      end
   end

   // Memory requests: write on accept, read while fetching
   always_comb begin
      mem_req.wr_en   = req_take;
      mem_req.wr_addr = fill_ff[ADDR_W-1:0];
      mem_req.wr_data = req_item_value;
      mem_req.rd_en   = (state_ff == S_FETCH);
      mem_req.rd_addr = idx_ff;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_list_done   = rsp_done_ff;
   assign status.busy     = (state_ff != S_IDLE);
   assign status.fill     = fill_ff;

endmodule

// ===== design/k_group_stream_reverser_core.sv =====
// Top level of the k-group stream reverser: group size register,
// sequencer and group buffer. Depends on kgsr_pkg, kgsr_seq, kgsr_group_mem.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_item_value, req_end_of_list
//   rsp      out        rsp_valid / rsp_stall   rsp_out_value, rsp_last_of_run,
//                                               rsp_list_done
//   csr      in         csr_wr_en               csr_wr_data (group size)
//
// An item that does not flush is taken without a stall. An item that flushes
// a group holds req_stall high while the group is read back: each result is a
// buffer read (S_FETCH), then a result register load (S_LOAD) held by rsp_stall.
// Reset (synchronous, active high) empties the buffer count and sets group size 2.
// rsp_stall only delays loading the result register; a new item is taken while
// a result still waits.
module k_group_stream_reverser_core
   import kgsr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_item_value,
   input  logic                         req_end_of_list,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value,
   output logic                         rsp_last_of_run,
   output logic                         rsp_list_done,
   input  logic                         csr_wr_en,
   input  logic [CFG_W-1:0]             csr_wr_data
);

   logic [CFG_W-1:0]      group_size_ff;
   logic [CNT_W-1:0]      group_k;
   mem_req_type           mem_req;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [DATA_WIDTH-1:0] out_value;
   seq_status_type        status;

   // Hold the group size register
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_wr_en) begin
         group_size_ff <= csr_wr_data;
      end
   end

   assign group_k = effective_group(group_size_ff);

   kgsr_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .group_k         (group_k),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item_value  (req_item_value),
      .req_end_of_list (req_end_of_list),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_list_done   (rsp_list_done),
      .mem_req         (mem_req),
      .rd_data         (rd_data),
      .status          (status)
   );

   kgsr_group_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_out_value = out_value;

   // The buffer count never reaches the buffer depth between items
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      status.fill < CNT_W'(MAX_GROUP))
      else $error("fill count reached buffer depth");

   // The buffer is empty while a group is read back
   a_busy_empty: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> status.fill == '0)
      else $error("items stored while flushing");

   // End of list always empties the buffer
   a_eol_flush: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_list) |=> status.fill == '0)
      else $error("end of list left items stored");

   // End of output list is the last result of its run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_list_done) |-> rsp_last_of_run)
      else $error("list_done without last_of_run");

endmodule
